// ===== sv/pna_pkg.sv =====
// ----------------------------------------------------------------------------
// pna_pkg
// Shared types, codes and small helper functions for the proportional
// navigation acceleration command unit.
// ----------------------------------------------------------------------------
package pna_pkg;

  localparam int VEC_W = 32;
  localparam int DIV_DW = 81;
  localparam int DIV_QW = 41;

  localparam logic [2:0] OP_ROW0 = 3'd0;
  localparam logic [2:0] OP_ROW1 = 3'd1;
  localparam logic [2:0] OP_ROW2 = 3'd2;
  localparam logic [2:0] OP_VEL  = 3'd3;
  localparam logic [2:0] OP_POS  = 3'd4;

  localparam logic [1:0] REG_GAIN = 2'd0;
  localparam logic [1:0] REG_MAXA = 2'd1;

  typedef struct packed {
    logic [2:0]              op;
    logic signed [VEC_W-1:0] vec_x;
    logic signed [VEC_W-1:0] vec_y;
    logic signed [VEC_W-1:0] vec_z;
  } pna_in_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] normal_cmd;
    logic signed [VEC_W-1:0] side_cmd;
    logic                    limited;
    logic                    status;
  } pna_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_R2,
    ST_RSQ,
    ST_V2,
    ST_SSQ,
    ST_CM,
    ST_U,
    ST_T,
    ST_Q,
    ST_G,
    ST_CMD,
    ST_LIM,
    ST_MSQ,
    ST_SCL,
    ST_OUT
  } pna_state_e;

  typedef struct packed {
    pna_state_e state;
    logic [3:0] ix;
    logic [2:0] step;
    logic       accept;
    logic       out_load;
  } pna_cmd_t;

  typedef struct packed {
    logic r2_zero;
    logic sq_done;
    logic div_done;
    logic lim;
  } pna_sts_t;

  function automatic logic signed [VEC_W-1:0] sat32(input logic signed [65:0] x);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (x > hi) begin
      return 32'sh7fffffff;
    end else if (x < lo) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  function automatic logic [32:0] abs32(input logic signed [31:0] x);
    logic signed [32:0] xe;
    xe = {x[31], x};
    return x[31] ? 33'(-xe) : 33'(xe);
  endfunction

  function automatic logic [32:0] abs34(input logic signed [33:0] x);
    logic signed [33:0] xn;
    xn = -x;
    return x[33] ? xn[32:0] : x[32:0];
  endfunction

  function automatic logic [1:0] nxt3(input logic [1:0] i);
    logic [1:0] r;
    unique case (i)
      2'd0: r = 2'd1;
      2'd1: r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] div3(input logic [3:0] i);
    logic [1:0] r;
    if (i < 4'd3) begin
      r = 2'd0;
    end else if (i < 4'd6) begin
      r = 2'd1;
    end else begin
      r = 2'd2;
    end
    return r;
  endfunction

  function automatic logic [1:0] mod3(input logic [3:0] i);
    logic [1:0] r;
    unique case (i)
      4'd0, 4'd3, 4'd6: r = 2'd0;
      4'd1, 4'd4, 4'd7: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/pro_nav_accel_command_unit.sv =====
// ----------------------------------------------------------------------------
// pro_nav_accel_command_unit
// Proportional navigation acceleration command unit.
//
// Input beats carry an op code and a three-component vector. Ops 0 to 2
// load a row of the orientation matrix and op 3 loads the own velocity;
// these are taken and give no result. Op 4 carries the relative
// position and produces one output beat with the normal and side commands.
// Ops 5 to 7 are taken and dropped.
// A position beat uses the shared multiplier, the one-bit-per-cycle square
// root unit (up to three runs) and the one-bit-per-cycle divider (up to seven
// runs), and takes longer when the command is limited. The next beat is
// accepted once the result has moved to the output register, even while
// that register waits.
// If the receiver stalls with a result pending, the next computation finishes
// and holds until the output register frees up.
// Reset clears the matrix and velocity to zero, sets the gain to three and
// the limit to its default, and leaves no result pending.
// ----------------------------------------------------------------------------
module pro_nav_accel_command_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pna_pkg::pna_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pna_pkg::pna_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [30:0]       cfg_data_i
);

  pna_pkg::pna_cmd_t cmd;
  pna_pkg::pna_sts_t sts;

  pna_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_data_i.op),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pna_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

// ===== sv/pna_sqrt.sv =====
// ----------------------------------------------------------------------------
// pna_sqrt
// Iterative integer square root of a 64-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
module pna_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] x_i,
  output logic        done_o,
  output logic [31:0] root_o,
  output logic        rem_nz_o
);

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [63:0] x_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic [35:0] diff;
  logic        ge;

  assign rem_sh = {rem_q, x_q[63:62]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign ge     = rem_sh >= trial;
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 5'd31);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= x_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q    <= {x_q[61:0], 2'b00};
      rem_q  <= ge ? diff[33:0] : rem_sh[33:0];
      root_q <= {root_q[30:0], ge};
    end
  end

  assign done_o   = done_q;
  assign root_o   = root_q;
  assign rem_nz_o = (rem_q != '0);

endmodule

// ===== sv/pna_div.sv =====
// ----------------------------------------------------------------------------
// pna_div
// Restoring unsigned divider, one quotient bit per cycle, with the quotient
// capped at two to the fortieth.
// ----------------------------------------------------------------------------
module pna_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pna_pkg::DIV_DW-1:0]   dividend_i,
  input  logic [pna_pkg::DIV_QW-1:0]   divisor_i,
  output logic                         done_o,
  output logic [pna_pkg::DIV_QW-1:0]   quo_o
);

  localparam logic [pna_pkg::DIV_QW-1:0] CAP = {1'b1, {(pna_pkg::DIV_QW-1){1'b0}}};

  logic                        busy_q;
  logic                        done_q;
  logic [5:0]                  cnt_q;
  logic                        sat_q;
  logic [pna_pkg::DIV_QW-1:0]  num_q;
  logic [pna_pkg::DIV_QW-1:0]  rem_q;
  logic [pna_pkg::DIV_QW-1:0]  quo_q;
  logic [pna_pkg::DIV_QW-1:0]  dsr_q;
  logic [pna_pkg::DIV_QW:0]    rem_sh;
  logic [pna_pkg::DIV_QW:0]    diff;
  logic                        ge;

  assign rem_sh = {rem_q, num_q[pna_pkg::DIV_QW-1]};
  assign ge     = rem_sh >= {1'b0, dsr_q};
  assign diff   = rem_sh - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 6'd40);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd40) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sat_q <= {1'b0, dividend_i[pna_pkg::DIV_DW-1:pna_pkg::DIV_QW]} >= divisor_i;
      rem_q <= {1'b0, dividend_i[pna_pkg::DIV_DW-1:pna_pkg::DIV_QW]};
      num_q <= dividend_i[pna_pkg::DIV_QW-1:0];
      dsr_q <= divisor_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[pna_pkg::DIV_QW-1:0] : rem_sh[pna_pkg::DIV_QW-1:0];
      num_q <= {num_q[pna_pkg::DIV_QW-2:0], 1'b0};
      quo_q <= {quo_q[pna_pkg::DIV_QW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = (sat_q || (quo_q > CAP)) ? CAP : quo_q;

endmodule

// ===== sv/pna_dp.sv =====
// ----------------------------------------------------------------------------
// pna_dp
// Datapath: stored vectors and registers, one shared multiplier, the
// accumulator, and the square root and divider units.
// ----------------------------------------------------------------------------
module pna_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pna_pkg::pna_cmd_t cmd_i,
  input  pna_pkg::pna_in_t  in_data_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [30:0]       cfg_data_i,
  output pna_pkg::pna_sts_t sts_o,
  output pna_pkg::pna_out_t out_data_o
);

  logic signed [31:0] mat_q [9];
  logic signed [31:0] v_q [3];
  logic signed [31:0] p_q [3];
  logic signed [31:0] c_q [3];
  logic signed [31:0] u_q [3];
  logic signed [31:0] t_q [3];
  logic signed [33:0] q_q [2];
  logic [15:0]        gain_q;
  logic [30:0]        maxa_q;
  logic [31:0]        r_q;
  logic [31:0]        s_q;
  logic [47:0]        g_q;
  logic [32:0]        mgn_q;
  logic signed [31:0] nrm_q;
  logic signed [31:0] sid_q;
  logic               lim_q;
  logic               stat_q;
  pna_pkg::pna_out_t  out_q;
  logic signed [65:0] acc_q;
  logic signed [67:0] prod_q;
  logic [pna_pkg::DIV_DW-1:0] divd_q;

  pna_pkg::pna_state_e st;
  logic [3:0]         ix;
  logic [2:0]         step;
  logic [1:0]         comp;
  logic [1:0]         a_sel;
  logic [1:0]         b_sel;
  logic [1:0]         ci;
  logic [1:0]         cj;
  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [67:0] prod_d;
  logic signed [65:0] prod66;
  logic signed [65:0] prod_q2;
  logic signed [65:0] cm_sum;
  logic signed [65:0] xd;
  logic signed [65:0] xs;
  logic signed [65:0] cm_sh;
  logic signed [33:0] negv;
  logic signed [31:0] vj;
  logic [32:0]        mag;
  logic [32:0]        sc_abs;
  logic signed [31:0] sc_val;
  logic [32:0]        pabs;
  logic               sq_start;
  logic [31:0]        sq_root;
  logic               sq_rem_nz;
  logic               sq_done;
  logic               div_start;
  logic [pna_pkg::DIV_QW-1:0] dsr;
  logic [pna_pkg::DIV_QW-1:0] quo;
  logic               div_done;
  logic               r2_zero;
  logic               lim;
  logic signed [31:0] cmd_val;

  assign st    = cmd_i.state;
  assign ix    = cmd_i.ix;
  assign step  = cmd_i.step;
  assign comp  = ix[2:1];
  assign a_sel = ix[0] ? pna_pkg::nxt3(pna_pkg::nxt3(comp)) : pna_pkg::nxt3(comp);
  assign b_sel = ix[0] ? pna_pkg::nxt3(comp) : pna_pkg::nxt3(pna_pkg::nxt3(comp));
  assign ci    = pna_pkg::div3(ix);
  assign cj    = pna_pkg::mod3(ix);
  assign vj    = v_q[cj];
  assign negv  = -$signed({{2{vj[31]}}, vj});
  assign mag   = pna_pkg::abs34(q_q[ix[1]]);
  assign sc_val = ix[0] ? sid_q : nrm_q;
  assign sc_abs = pna_pkg::abs32(sc_val);
  assign pabs  = pna_pkg::abs32(p_q[ix[1:0]]);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (st)
      pna_pkg::ST_R2: begin
        mul_a = 34'(p_q[ix[1:0]]);
        mul_b = 34'(p_q[ix[1:0]]);
      end
      pna_pkg::ST_V2: begin
        mul_a = 34'(v_q[ix[1:0]]);
        mul_b = 34'(v_q[ix[1:0]]);
      end
      pna_pkg::ST_CM: begin
        mul_a = 34'(mat_q[ix]);
        mul_b = negv;
      end
      pna_pkg::ST_T: begin
        mul_a = 34'(u_q[a_sel]);
        mul_b = 34'(c_q[b_sel]);
      end
      pna_pkg::ST_Q: begin
        mul_a = 34'(u_q[a_sel]);
        mul_b = 34'(t_q[b_sel]);
      end
      pna_pkg::ST_G: begin
        mul_a = $signed({18'd0, gain_q});
        mul_b = $signed({2'd0, s_q});
      end
      pna_pkg::ST_CMD: begin
        mul_a = (step == 3'd0) ? $signed({10'd0, g_q[23:0]}) : $signed({10'd0, g_q[47:24]});
        mul_b = $signed({1'b0, mag});
      end
      pna_pkg::ST_LIM: begin
        if (step == 3'd0) begin
          mul_a = 34'(nrm_q);
          mul_b = 34'(nrm_q);
        end else if (step == 3'd2) begin
          mul_a = 34'(sid_q);
          mul_b = 34'(sid_q);
        end else begin
          mul_a = $signed({3'd0, maxa_q});
          mul_b = $signed({3'd0, maxa_q});
        end
      end
      pna_pkg::ST_SCL: begin
        mul_a = $signed({1'b0, sc_abs});
        mul_b = $signed({3'd0, maxa_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d  = mul_a * mul_b;
  assign prod66  = prod_q[65:0];
  assign prod_q2 = prod_q[67:2];
  assign cm_sum  = ((cj == 2'd0) ? 66'sd0 : acc_q) + prod_q2;
  assign cm_sh   = cm_sum >>> 28;
  assign xd      = acc_q - prod66;
  assign xs      = xd >>> 30;
  assign r2_zero = (acc_q[63:0] == '0);
  assign lim     = {{2{acc_q[65]}}, acc_q} > prod_q;

  always_comb begin
    if (q_q[ix[1]][33]) begin
      cmd_val = (quo > 41'h7fffffff) ? 32'sh7fffffff : quo[31:0];
    end else begin
      cmd_val = (quo > 41'h80000000) ? 32'sh80000000 : -quo[31:0];
    end
  end

  assign sq_start = ((st == pna_pkg::ST_RSQ) && (step == 3'd0) && !r2_zero) ||
                    ((st == pna_pkg::ST_SSQ) && (step == 3'd0)) ||
                    ((st == pna_pkg::ST_MSQ) && (step == 3'd0));
  assign div_start = ((st == pna_pkg::ST_U) && (step == 3'd1)) ||
                     ((st == pna_pkg::ST_CMD) && (step == 3'd4)) ||
                     ((st == pna_pkg::ST_SCL) && (step == 3'd2));

  always_comb begin
    unique case (st)
      pna_pkg::ST_U:   dsr = {9'd0, r_q};
      pna_pkg::ST_CMD: dsr = {1'b0, r_q, 8'd0};
      pna_pkg::ST_SCL: dsr = {8'd0, mgn_q};
      default:         dsr = '0;
    endcase
  end

  pna_sqrt u_sqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (sq_start),
    .x_i      (acc_q[63:0]),
    .done_o   (sq_done),
    .root_o   (sq_root),
    .rem_nz_o (sq_rem_nz)
  );

  pna_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (divd_q),
    .divisor_i  (dsr),
    .done_o     (div_done),
    .quo_o      (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= 16'd768;
      maxa_q <= 31'd409600;
      for (int k = 0; k < 9; k++) begin
        mat_q[k] <= '0;
      end
      for (int k = 0; k < 3; k++) begin
        v_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          pna_pkg::REG_GAIN: gain_q <= cfg_data_i[15:0];
          pna_pkg::REG_MAXA: maxa_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        unique case (in_data_i.op)
          pna_pkg::OP_ROW0, pna_pkg::OP_ROW1, pna_pkg::OP_ROW2: begin
            mat_q[4'(in_data_i.op) * 4'd3]        <= in_data_i.vec_x;
            mat_q[4'(in_data_i.op) * 4'd3 + 4'd1] <= in_data_i.vec_y;
            mat_q[4'(in_data_i.op) * 4'd3 + 4'd2] <= in_data_i.vec_z;
          end
          pna_pkg::OP_VEL: begin
            v_q[0] <= in_data_i.vec_x;
            v_q[1] <= in_data_i.vec_y;
            v_q[2] <= in_data_i.vec_z;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.accept && (in_data_i.op == pna_pkg::OP_POS)) begin
      p_q[0] <= in_data_i.vec_x;
      p_q[1] <= in_data_i.vec_y;
      p_q[2] <= in_data_i.vec_z;
      stat_q <= 1'b0;
      lim_q  <= 1'b0;
    end
    if (cmd_i.out_load) begin
      out_q.normal_cmd <= nrm_q;
      out_q.side_cmd   <= sid_q;
      out_q.limited    <= lim_q;
      out_q.status     <= stat_q;
    end
    unique case (st)
      pna_pkg::ST_R2, pna_pkg::ST_V2: begin
        if (step == 3'd1) begin
          acc_q <= ((ix == 4'd0) ? 66'sd0 : acc_q) + prod66;
        end
      end
      pna_pkg::ST_RSQ: begin
        if ((step == 3'd0) && r2_zero) begin
          nrm_q  <= '0;
          sid_q  <= '0;
          lim_q  <= 1'b0;
          stat_q <= 1'b1;
        end
        if (sq_done) begin
          r_q <= sq_root;
        end
      end
      pna_pkg::ST_SSQ: begin
        if (sq_done) begin
          s_q <= sq_root;
        end
      end
      pna_pkg::ST_CM: begin
        if (step == 3'd1) begin
          acc_q <= cm_sum;
          if (cj == 2'd2) begin
            c_q[ci] <= pna_pkg::sat32(cm_sh);
          end
        end
      end
      pna_pkg::ST_U: begin
        if (step == 3'd0) begin
          divd_q <= {19'd0, pabs[31:0], 30'd0};
        end
        if (div_done) begin
          u_q[ix[1:0]] <= p_q[ix[1:0]][31] ? -quo[31:0] : quo[31:0];
        end
      end
      pna_pkg::ST_T: begin
        if (step == 3'd1) begin
          if (!ix[0]) begin
            acc_q <= prod66;
          end else begin
            t_q[comp] <= pna_pkg::sat32(xs);
          end
        end
      end
      pna_pkg::ST_Q: begin
        if (step == 3'd1) begin
          if (!ix[0]) begin
            acc_q <= prod66;
          end else begin
            q_q[comp[1]] <= xs[33:0];
          end
        end
      end
      pna_pkg::ST_G: begin
        if (step == 3'd1) begin
          g_q <= prod_q[47:0];
        end
      end
      pna_pkg::ST_CMD: begin
        if (step == 3'd1) begin
          divd_q <= {13'd0, prod_q};
        end else if (step == 3'd3) begin
          divd_q <= divd_q + {prod_q[56:0], 24'd0};
        end
        if (div_done) begin
          if (ix[1]) begin
            nrm_q <= cmd_val;
          end else begin
            sid_q <= cmd_val;
          end
        end
      end
      pna_pkg::ST_LIM: begin
        if (step == 3'd1) begin
          acc_q <= prod66;
        end else if (step == 3'd3) begin
          acc_q <= acc_q + prod66;
        end else if (step == 3'd5) begin
          lim_q <= lim;
        end
      end
      pna_pkg::ST_MSQ: begin
        if (sq_done) begin
          mgn_q <= {1'b0, sq_root} + {32'd0, sq_rem_nz};
        end
      end
      pna_pkg::ST_SCL: begin
        if (step == 3'd1) begin
          divd_q <= {13'd0, prod_q};
        end
        if (div_done) begin
          if (ix[0]) begin
            sid_q <= sid_q[31] ? -quo[31:0] : quo[31:0];
          end else begin
            nrm_q <= nrm_q[31] ? -quo[31:0] : quo[31:0];
          end
        end
      end
      default: ;
    endcase
  end

  assign sts_o.r2_zero  = r2_zero;
  assign sts_o.sq_done  = sq_done;
  assign sts_o.div_done = div_done;
  assign sts_o.lim      = lim;
  assign out_data_o     = out_q;

endmodule

// ===== sv/pna_ctrl.sv =====
// ----------------------------------------------------------------------------
// pna_ctrl
// Controller: handshakes and the state machine that steps the datapath
// through each phase of the guidance computation.
// ----------------------------------------------------------------------------
module pna_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [2:0]        in_op_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  pna_pkg::pna_sts_t sts_i,
  output pna_pkg::pna_cmd_t cmd_o
);

  pna_pkg::pna_state_e state_q, state_d;
  logic [3:0] ix_q, ix_d;
  logic [2:0] st_q, st_d;
  logic       out_valid_q, out_valid_d;
  logic       in_ready;
  logic       accept;
  logic       out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pna_pkg::ST_IDLE;
      ix_q        <= '0;
      st_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ix_q        <= ix_d;
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    ix_d     = ix_q;
    st_d     = st_q;
    in_ready = 1'b0;
    accept   = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      pna_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid_i) begin
          accept = 1'b1;
          if (in_op_i == pna_pkg::OP_POS) begin
            state_d = pna_pkg::ST_R2;
            ix_d    = '0;
            st_d    = '0;
          end
        end
      end
      pna_pkg::ST_R2, pna_pkg::ST_V2: begin
        if (st_q == 3'd0) begin
          st_d = 3'd1;
        end else begin
          st_d = 3'd0;
          if (ix_q == 4'd2) begin
            ix_d    = '0;
            state_d = (state_q == pna_pkg::ST_R2) ? pna_pkg::ST_RSQ : pna_pkg::ST_SSQ;
          end else begin
            ix_d = ix_q + 4'd1;
          end
        end
      end
      pna_pkg::ST_RSQ: begin
        if (st_q == 3'd0) begin
          if (sts_i.r2_zero) begin
            state_d = pna_pkg::ST_OUT;
          end else begin
            st_d = 3'd1;
          end
        end else if (sts_i.sq_done) begin
          st_d    = 3'd0;
          state_d = pna_pkg::ST_V2;
        end
      end
      pna_pkg::ST_SSQ: begin
        if (st_q == 3'd0) begin
          st_d = 3'd1;
        end else if (sts_i.sq_done) begin
          st_d    = 3'd0;
          state_d = pna_pkg::ST_CM;
        end
      end
      pna_pkg::ST_CM: begin
        if (st_q == 3'd0) begin
          st_d = 3'd1;
        end else begin
          st_d = 3'd0;
          if (ix_q == 4'd8) begin
            ix_d    = '0;
            state_d = pna_pkg::ST_U;
          end else begin
            ix_d = ix_q + 4'd1;
          end
        end
      end
      pna_pkg::ST_U: begin
        if (st_q != 3'd2) begin
          st_d = st_q + 3'd1;
        end else if (sts_i.div_done) begin
          st_d = 3'd0;
          if (ix_q == 4'd2) begin
            ix_d    = '0;
            state_d = pna_pkg::ST_T;
          end else begin
            ix_d = ix_q + 4'd1;
          end
        end
      end
      pna_pkg::ST_T, pna_pkg::ST_Q: begin
        if (st_q == 3'd0) begin
          st_d = 3'd1;
        end else begin
          st_d = 3'd0;
          if (ix_q == 4'd5) begin
            if (state_q == pna_pkg::ST_T) begin
              ix_d    = 4'd2;
              state_d = pna_pkg::ST_Q;
            end else begin
              ix_d    = '0;
              state_d = pna_pkg::ST_G;
            end
          end else begin
            ix_d = ix_q + 4'd1;
          end
        end
      end
      pna_pkg::ST_G: begin
        if (st_q == 3'd0) begin
          st_d = 3'd1;
        end else begin
          st_d    = 3'd0;
          ix_d    = 4'd1;
          state_d = pna_pkg::ST_CMD;
        end
      end
      pna_pkg::ST_CMD: begin
        if (st_q != 3'd5) begin
          st_d = st_q + 3'd1;
        end else if (sts_i.div_done) begin
          st_d = 3'd0;
          if (ix_q == 4'd2) begin
            ix_d    = '0;
            state_d = pna_pkg::ST_LIM;
          end else begin
            ix_d = ix_q + 4'd1;
          end
        end
      end
      pna_pkg::ST_LIM: begin
        if (st_q != 3'd5) begin
          st_d = st_q + 3'd1;
        end else begin
          st_d    = 3'd0;
          state_d = sts_i.lim ? pna_pkg::ST_MSQ : pna_pkg::ST_OUT;
        end
      end
      pna_pkg::ST_MSQ: begin
        if (st_q == 3'd0) begin
          st_d = 3'd1;
        end else if (sts_i.sq_done) begin
          st_d    = 3'd0;
          ix_d    = '0;
          state_d = pna_pkg::ST_SCL;
        end
      end
      pna_pkg::ST_SCL: begin
        if (st_q != 3'd3) begin
          st_d = st_q + 3'd1;
        end else if (sts_i.div_done) begin
          st_d = 3'd0;
          if (ix_q == 4'd1) begin
            ix_d    = '0;
            state_d = pna_pkg::ST_OUT;
          end else begin
            ix_d = ix_q + 4'd1;
          end
        end
      end
      pna_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          st_d     = 3'd0;
          ix_d     = '0;
          state_d  = pna_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pna_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign in_ready_o     = in_ready;
  assign out_valid_o    = out_valid_q;
  assign cmd_o.state    = state_q;
  assign cmd_o.ix       = ix_q;
  assign cmd_o.step     = st_q;
  assign cmd_o.accept   = accept;
  assign cmd_o.out_load = out_load;

  a_sq_done_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.sq_done |-> (st_q == 3'd1) && ((state_q == pna_pkg::ST_RSQ) ||
      (state_q == pna_pkg::ST_SSQ) || (state_q == pna_pkg::ST_MSQ)))
    else $error("square root finished outside a wait step");

  a_div_done_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> ((state_q == pna_pkg::ST_U) && (st_q == 3'd2)) ||
      ((state_q == pna_pkg::ST_CMD) && (st_q == 3'd5)) ||
      ((state_q == pna_pkg::ST_SCL) && (st_q == 3'd3)))
    else $error("division finished outside a wait step");

  a_pos_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_op_i == pna_pkg::OP_POS)) |=>
      (state_q == pna_pkg::ST_R2))
    else $error("position beat did not start the computation");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("pending result overwritten");

endmodule

// ===== verif/pro_nav_accel_command_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pro_nav_accel_command_unit_tb
// Self-checking bench for the proportional navigation command unit. Matrix
// rows, own velocity and position beats go in over a valid/ready channel; a
// bit-exact guidance predictor computes the expected normal and side
// commands, limit flag and status of each position beat, and every output
// beat is checked in order against them. Gain and limit are swept between
// phases, and both channels are throttled and stalled at random.
// ----------------------------------------------------------------------------
module pro_nav_accel_command_unit_tb;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  pna_pkg::pna_in_t  in_data_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  pna_pkg::pna_out_t out_data_o;
  logic              cfg_we_i = 1'b0;
  logic [1:0]        cfg_idx_i = pna_pkg::REG_GAIN;
  logic [30:0]       cfg_data_i = '0;

  pro_nav_accel_command_unit u_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state.
  longint   orient[9];
  longint   own_vel[3];
  logic [15:0] gain_q88 = 16'd768;
  logic [30:0] accel_lim = 31'd409600;

  pna_pkg::pna_out_t cmd_q[$];
  int       n_fail = 0;
  int       n_cmds = 0;
  int       n_limited = 0;
  int       n_zero_rng = 0;
  int       n_beats = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint sat_vec(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic void cross30(input longint a[3], input longint b[3],
                                  output longint z[3]);
    z[0] = (a[1] * b[2] - a[2] * b[1]) >>> 30;
    z[1] = (a[2] * b[0] - a[0] * b[2]) >>> 30;
    z[2] = (a[0] * b[1] - a[1] * b[0]) >>> 30;
  endfunction

  // Updates the stored matrix and velocity; returns 1 when a command results.
  function automatic bit guidance_cmd(input pna_pkg::pna_in_t it,
                                      output pna_pkg::pna_out_t res);
    longint p[3], c[3], u[3], t[3], q[3], cmd[3];
    longint acc, m, nrm, sid;
    logic [63:0] r2, v2, r, s, g, mag, an, as, sum, mx, mm;
    logic [127:0] prod, quo;
    res = '0;
    p[0] = longint'(it.vec_x);
    p[1] = longint'(it.vec_y);
    p[2] = longint'(it.vec_z);
    if (it.op inside {pna_pkg::OP_ROW0, pna_pkg::OP_ROW1, pna_pkg::OP_ROW2}) begin
      for (int j = 0; j < 3; j++) orient[it.op * 3 + j] = p[j];
      return 0;
    end
    if (it.op == pna_pkg::OP_VEL) begin
      for (int j = 0; j < 3; j++) own_vel[j] = p[j];
      return 0;
    end
    if (it.op != pna_pkg::OP_POS) return 0;
    r2 = 0;
    v2 = 0;
    for (int i = 0; i < 3; i++) begin
      r2 += 64'(p[i] * p[i]);
      v2 += 64'(own_vel[i] * own_vel[i]);
    end
    if (r2 == 0) begin
      res.status = 1'b1;
      return 1;
    end
    r = int_sqrt(r2);
    s = int_sqrt(v2);
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += (orient[i * 3 + j] * (-own_vel[j])) >>> 2;
      c[i] = sat_vec(acc >>> 28);
      u[i] = (p[i] * 64'sd1073741824) / longint'(r);
    end
    cross30(u, c, t);
    for (int i = 0; i < 3; i++) t[i] = sat_vec(t[i]);
    cross30(u, t, q);
    g = 64'(gain_q88) * s;
    for (int i = 1; i < 3; i++) begin
      mag = (q[i] < 0) ? 64'(-q[i]) : 64'(q[i]);
      prod = {64'd0, g} * {64'd0, mag};
      quo = prod / ({64'd0, r} << 8);
      if (quo >= (128'd1 << 40)) quo = 128'd1 << 40;
      m = longint'(quo[63:0]);
      cmd[i] = sat_vec(q[i] < 0 ? m : -m);
    end
    nrm = cmd[2];
    sid = cmd[1];
    mx = 64'(accel_lim);
    an = 64'(nrm < 0 ? -nrm : nrm);
    as = 64'(sid < 0 ? -sid : sid);
    sum = an * an + as * as;
    if (sum > mx * mx) begin
      mm = int_sqrt(sum);
      if (mm * mm < sum) mm++;
      nrm = (nrm * longint'(mx)) / longint'(mm);
      sid = (sid * longint'(mx)) / longint'(mm);
      res.limited = 1'b1;
    end
    res.normal_cmd = nrm[31:0];
    res.side_cmd = sid[31:0];
    return 1;
  endfunction

  // One input beat, sometimes with a random gap first.
  task automatic send_beat(input logic [2:0] op, input logic [31:0] x,
                           input logic [31:0] y, input logic [31:0] z);
    pna_pkg::pna_in_t it;
    pna_pkg::pna_out_t exp_cmd;
    bit took;
    it = '{op: op, vec_x: x, vec_y: y, vec_z: z};
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
    n_beats++;
    if (guidance_cmd(it, exp_cmd)) cmd_q.push_back(exp_cmd);
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (cmd_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == pna_pkg::REG_GAIN) gain_q88 = val[15:0];
    else if (idx == pna_pkg::REG_MAXA) accel_lim = val;
  endtask

  // Mostly plausible magnitudes, sometimes full range or extremes.
  function automatic logic [31:0] rand_word(input int shift);
    int k;
    k = $urandom_range(99);
    if (k < 4) return 32'h8000_0000;
    if (k < 8) return 32'h7fff_ffff;
    if (k < 10) return 32'd0;
    if (k < 25) return $urandom;
    return 32'($signed($urandom) >>> shift);
  endfunction

  task automatic send_pos();
    send_beat(pna_pkg::OP_POS, rand_word(4), rand_word(4), rand_word(4));
  endtask

  task automatic send_guidance_set(input int n_pos);
    send_beat(pna_pkg::OP_ROW0, rand_word(1), rand_word(1), rand_word(1));
    send_beat(pna_pkg::OP_ROW1, rand_word(1), rand_word(1), rand_word(1));
    send_beat(pna_pkg::OP_ROW2, rand_word(1), rand_word(1), rand_word(1));
    send_beat(pna_pkg::OP_VEL, rand_word(8), rand_word(8), rand_word(8));
    repeat (n_pos) send_pos();
  endtask

  task automatic test_directed();
    // Identity matrix, zero speed first.
    send_beat(pna_pkg::OP_ROW0, 32'h4000_0000, 0, 0);
    send_beat(pna_pkg::OP_ROW1, 0, 32'h4000_0000, 0);
    send_beat(pna_pkg::OP_ROW2, 0, 0, 32'h4000_0000);
    send_beat(pna_pkg::OP_POS, 32'd409600, 32'd4096, 32'd8192);
    send_beat(pna_pkg::OP_POS, 0, 0, 0);
    send_beat(pna_pkg::OP_VEL, -32'sd1228800, 32'd40960, -32'sd20480);
    send_beat(pna_pkg::OP_POS, 32'd4096000, 32'd409600, -32'sd204800);
    send_beat(pna_pkg::OP_POS, 0, 0, 32'd1);
    send_beat(3'd5, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_beat(3'd6, 32'h1234_5678, 0, 0);
    send_beat(3'd7, 0, 32'h8000_0000, 0);
    send_beat(pna_pkg::OP_POS, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_beat(pna_pkg::OP_POS, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_beat(pna_pkg::OP_VEL, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_beat(pna_pkg::OP_ROW0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_beat(pna_pkg::OP_ROW1, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_beat(pna_pkg::OP_ROW2, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_beat(pna_pkg::OP_POS, 32'd1, 32'h8000_0000, 32'd7);
    send_beat(pna_pkg::OP_POS, 0, 32'd4096, 0);
    send_beat(pna_pkg::OP_POS, 0, 0, 0);
    wait_drain();
  endtask

  task automatic test_random(input int n_items, input int idle, input int stall);
    int sent;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        send_beat(3'($urandom), $urandom, $urandom, $urandom);
        sent++;
      end else begin
        send_guidance_set($urandom_range(1, 3));
        sent += 6;
      end
      if ($urandom_range(19) == 0) wait_drain();
    end
    wait_drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1500;
    send_guidance_set(6);
    wait_drain();
  endtask

  task automatic test_limits();
    logic [30:0] lim_set[4] = '{31'd0, 31'h7fff_ffff, 31'd2048, 31'd409600};
    logic [30:0] gain_set[4] = '{31'd0, 31'd65535, 31'd128, 31'd768};
    for (int k = 0; k < 4; k++) begin
      write_reg(pna_pkg::REG_MAXA, lim_set[k]);
      write_reg(pna_pkg::REG_GAIN, gain_set[k]);
      test_random(60, 34, 34);
    end
    write_reg(pna_pkg::REG_MAXA, 31'($urandom_range(1, 1 << 22)));
    write_reg(pna_pkg::REG_GAIN, 31'($urandom_range(0, 65535)));
    test_random(60, 0, 0);
    write_reg(pna_pkg::REG_MAXA, 31'd409600);
    write_reg(pna_pkg::REG_GAIN, 31'd768);
  endtask

  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(negedge clk_i) begin
    pna_pkg::pna_out_t exp_cmd;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cmd_q.size() == 0) begin
        $display("%0t: unexpected command beat %h", $time, out_data_o);
        n_fail++;
      end else begin
        exp_cmd = cmd_q.pop_front();
        n_cmds++;
        if (exp_cmd.limited) n_limited++;
        if (exp_cmd.status) n_zero_rng++;
        if (out_data_o.normal_cmd !== exp_cmd.normal_cmd) begin
          $display("%0t: normal_cmd expected %0d actual %0d", $time,
                   exp_cmd.normal_cmd, out_data_o.normal_cmd);
          n_fail++;
        end
        if (out_data_o.side_cmd !== exp_cmd.side_cmd) begin
          $display("%0t: side_cmd expected %0d actual %0d", $time,
                   exp_cmd.side_cmd, out_data_o.side_cmd);
          n_fail++;
        end
        if (out_data_o.limited !== exp_cmd.limited) begin
          $display("%0t: limited expected %b actual %b", $time,
                   exp_cmd.limited, out_data_o.limited);
          n_fail++;
        end
        if (out_data_o.status !== exp_cmd.status) begin
          $display("%0t: status expected %b actual %b", $time,
                   exp_cmd.status, out_data_o.status);
          n_fail++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < 9; i++) orient[i] = 0;
    for (int i = 0; i < 3; i++) own_vel[i] = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_limits();
    test_random(350, 0, 0);
    test_random(350, 67, 0);
    test_random(350, 0, 67);
    test_random(350, 34, 34);
    test_backpressure();
    if (cmd_q.size() != 0) begin
      $display("%0t: %0d expected commands never arrived", $time, cmd_q.size());
      n_fail++;
    end
    $display("Sent %0d beats; checked %0d commands (%0d limited, %0d zero range).",
             n_beats, n_cmds, n_limited, n_zero_rng);
    $display("Covered gain and limit extremes, throttling and a long output stall.");
    if (n_fail == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d commands outstanding.", cmd_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/pna_pkg.sv
sv/pna_sqrt.sv
sv/pna_div.sv
sv/pna_dp.sv
sv/pna_ctrl.sv
sv/pro_nav_accel_command_unit.sv
verif/pro_nav_accel_command_unit_tb.sv
